### src/catmull_rom_segment_eval_top_assert.svh
// Assertion macros for the Catmull-Rom segment evaluator top level.
`ifndef CATMULL_ROM_SEGMENT_EVAL_TOP_ASSERT_SVH
`define CATMULL_ROM_SEGMENT_EVAL_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define CRSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define CRSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/crse_pkg.sv
// Shared types and constants of the Catmull-Rom segment evaluator.
`timescale 1ns / 1ps

package crse_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int COORD_W      = 32;
  localparam int NODE_IDX_W   = 6;
  localparam int T_PARAM_W    = 17;
  localparam int NODE_COUNT_W = 7;

  // Four consecutive points always fall into four distinct banks.
  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = 2;

  // Index of the last register stage, which is the output register.
  localparam int STG_OUT = 9;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } crse_op_t;

  typedef enum logic [1:0] {
    ST_EVAL      = 2'd0,
    ST_WRITE_OK  = 2'd1,
    ST_BAD_SEG   = 2'd2,
    ST_BAD_INDEX = 2'd3
  } crse_status_t;

  typedef struct packed {
    crse_op_t                      operation;
    logic [NODE_IDX_W-1:0]         node_index;
    logic signed [COORD_W-1:0]     coord_x;
    logic signed [COORD_W-1:0]     coord_y;
    logic signed [COORD_W-1:0]     coord_z;
    logic [NODE_IDX_W-1:0]         segment_index;
    logic [T_PARAM_W-1:0]          t_param;
  } crse_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]     pos_x;
    logic signed [COORD_W-1:0]     pos_y;
    logic signed [COORD_W-1:0]     pos_z;
    logic signed [COORD_W-1:0]     slope_x;
    logic signed [COORD_W-1:0]     slope_y;
    logic signed [COORD_W-1:0]     slope_z;
    crse_status_t                  status;
  } crse_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } crse_point_t;

endpackage

### src/crse_bank_ram.sv
// One bank of the control point store: one write port, one registered read port.
`timescale 1ns / 1ps

module crse_bank_ram #(
  parameter int DEPTH = crse_pkg::MAX_NODES_DEF / crse_pkg::NUM_BANKS,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  crse_pkg::crse_point_t wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output crse_pkg::crse_point_t rd_data
);
  import crse_pkg::*;

  crse_point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/crse_axis_pipe.sv
// Per-axis datapath: coefficients, Horner steps for position and slope, saturation.
`timescale 1ns / 1ps

module crse_axis_pipe #(
  parameter int T_FRAC_BITS = crse_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                                  clk,
  input  logic [crse_pkg::STG_OUT-1:2]                          en,
  input  logic [crse_pkg::NUM_BANKS-1:0][crse_pkg::COORD_W-1:0] word,
  input  logic [crse_pkg::BANK_SEL_W-1:0]                       sel,
  input  logic [T_FRAC_BITS:0]                                  t_in,
  output logic signed [crse_pkg::COORD_W-1:0]                   pos,
  output logic signed [crse_pkg::COORD_W-1:0]                   slope
);
  import crse_pkg::*;

  // Coefficients and partial sums stay below 2^38 in magnitude.
  localparam int ACC_W  = 40;
  localparam int T_W    = T_FRAC_BITS + 1;
  localparam int PROD_W = ACC_W + T_W + 1;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (T_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  ACC_ONE  = ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  SAT_HI   = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0]  SAT_LO   = ~SAT_HI;

  // base + round(prod / 2^T): the base is placed above the fraction bits, and the
  // rounding half fills the empty fraction field, so a single add does both.
  function automatic logic signed [ACC_W-1:0] fold(input logic signed [PROD_W-1:0] prod,
                                                   input logic signed [ACC_W-1:0] base);
    logic signed [PROD_W-1:0] base_ext;
    logic signed [PROD_W-1:0] sum;
    base_ext = PROD_W'(base);
    base_ext = (base_ext <<< T_FRAC_BITS) | RND_HALF;
    sum      = prod + base_ext;
    sum      = sum >>> T_FRAC_BITS;
    return sum[ACC_W-1:0];
  endfunction

  // Round-half-up halving followed by saturation to 32 bits.
  function automatic logic signed [COORD_W-1:0] half_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] h;
    h = (v + ACC_ONE) >>> 1;
    if (h > SAT_HI) begin
      return SAT_HI[COORD_W-1:0];
    end else if (h < SAT_LO) begin
      return SAT_LO[COORD_W-1:0];
    end
    return h[COORD_W-1:0];
  endfunction

  logic signed [ACC_W-1:0]  p [NUM_BANKS];
  logic signed [ACC_W-1:0]  s2_a_nxt, s2_b_nxt, s2_c_nxt, s2_d_nxt, s2_d3_nxt;
  logic signed [ACC_W-1:0]  s2_a_r, s2_b_r, s2_c_r, s2_d_r, s2_d3_r;
  logic [T_W-1:0]           s2_t_r, s3_t_r, s4_t_r, s5_t_r, s6_t_r;
  logic signed [T_W:0]      ts2, ts4, ts6;

  logic signed [PROD_W-1:0] s3_prod_p_nxt, s3_prod_s_nxt, s3_prod_p_r, s3_prod_s_r;
  logic signed [ACC_W-1:0]  s3_a_r, s3_b_r, s3_c_r;
  logic signed [ACC_W-1:0]  s4_acc_p_nxt, s4_acc_s_nxt, s4_acc_p_r, s4_acc_s_r;
  logic signed [ACC_W-1:0]  s4_a_r, s4_b_r;
  logic signed [PROD_W-1:0] s5_prod_p_nxt, s5_prod_s_nxt, s5_prod_p_r, s5_prod_s_r;
  logic signed [ACC_W-1:0]  s5_a_r, s5_b_r;
  logic signed [ACC_W-1:0]  s6_acc_p_nxt, s6_acc_s_nxt, s6_acc_p_r, s6_acc_s_r;
  logic signed [ACC_W-1:0]  s6_a_r;
  logic signed [PROD_W-1:0] s7_prod_p_nxt, s7_prod_p_r;
  logic signed [COORD_W-1:0] s7_slope_nxt, s7_slope_r;
  logic signed [ACC_W-1:0]  s7_a_r;
  logic signed [ACC_W-1:0]  s8_acc_p_nxt, s8_acc_p_r;
  logic signed [COORD_W-1:0] s8_slope_r;

  // Point j of the segment sits in bank (sel + j) mod 4.
  always_comb begin
    for (int j = 0; j < NUM_BANKS; j++) begin
      p[j] = ACC_W'($signed(word[BANK_SEL_W'(sel + BANK_SEL_W'(j))]));
    end
    s2_a_nxt  = p[1] <<< 1;
    s2_b_nxt  = p[2] - p[0];
    s2_c_nxt  = (p[0] <<< 1) - (p[1] <<< 2) - p[1] + (p[2] <<< 2) - p[3];
    s2_d_nxt  = p[3] - p[0] + (p[1] <<< 1) + p[1] - (p[2] <<< 1) - p[2];
    s2_d3_nxt = ((p[3] - p[0]) <<< 1) + p[3] - p[0] + (p[1] <<< 3) + p[1]
                - (p[2] <<< 3) - p[2];
  end

  assign ts2 = $signed({1'b0, s2_t_r});
  assign ts4 = $signed({1'b0, s4_t_r});
  assign ts6 = $signed({1'b0, s6_t_r});

  always_comb begin
    s3_prod_p_nxt = s2_d_r * ts2;
    s3_prod_s_nxt = s2_d3_r * ts2;
    s4_acc_p_nxt  = fold(s3_prod_p_r, s3_c_r);
    s4_acc_s_nxt  = fold(s3_prod_s_r, s3_c_r <<< 1);
    s5_prod_p_nxt = s4_acc_p_r * ts4;
    s5_prod_s_nxt = s4_acc_s_r * ts4;
    s6_acc_p_nxt  = fold(s5_prod_p_r, s5_b_r);
    s6_acc_s_nxt  = fold(s5_prod_s_r, s5_b_r);
    s7_prod_p_nxt = s6_acc_p_r * ts6;
    s7_slope_nxt  = half_sat(s6_acc_s_r);
    s8_acc_p_nxt  = fold(s7_prod_p_r, s7_a_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_a_r  <= s2_a_nxt;
      s2_b_r  <= s2_b_nxt;
      s2_c_r  <= s2_c_nxt;
      s2_d_r  <= s2_d_nxt;
      s2_d3_r <= s2_d3_nxt;
      s2_t_r  <= t_in;
    end
    if (en[3]) begin
      s3_prod_p_r <= s3_prod_p_nxt;
      s3_prod_s_r <= s3_prod_s_nxt;
      s3_a_r      <= s2_a_r;
      s3_b_r      <= s2_b_r;
      s3_c_r      <= s2_c_r;
      s3_t_r      <= s2_t_r;
    end
    if (en[4]) begin
      s4_acc_p_r <= s4_acc_p_nxt;
      s4_acc_s_r <= s4_acc_s_nxt;
      s4_a_r     <= s3_a_r;
      s4_b_r     <= s3_b_r;
      s4_t_r     <= s3_t_r;
    end
    if (en[5]) begin
      s5_prod_p_r <= s5_prod_p_nxt;
      s5_prod_s_r <= s5_prod_s_nxt;
      s5_a_r      <= s4_a_r;
      s5_b_r      <= s4_b_r;
      s5_t_r      <= s4_t_r;
    end
    if (en[6]) begin
      s6_acc_p_r <= s6_acc_p_nxt;
      s6_acc_s_r <= s6_acc_s_nxt;
      s6_a_r     <= s5_a_r;
      s6_t_r     <= s5_t_r;
    end
    if (en[7]) begin
      s7_prod_p_r <= s7_prod_p_nxt;
      s7_slope_r  <= s7_slope_nxt;
      s7_a_r      <= s6_a_r;
    end
    if (en[8]) begin
      s8_acc_p_r <= s8_acc_p_nxt;
      s8_slope_r <= s7_slope_r;
    end
  end

  assign pos   = half_sat(s8_acc_p_r);
  assign slope = s8_slope_r;

endmodule

### src/catmull_rom_segment_eval_top.sv
// Top level of the Catmull-Rom segment evaluator: point store, control pipeline, output.
//
// The block stores up to MAX_NODES 3-D control points and evaluates uniform Catmull-Rom
// segments on them. Every input beat is either a point write or a segment evaluation, and
// every input beat yields exactly one output beat, in order. The block takes one beat per
// cycle when the output side does not stall, and passes it through nine register stages:
// the registered read of the point store, the coefficient stage, three multiply stages by t
// each followed by a rounding add stage, and the position's halving and saturation into
// the output register. The point store is split into four banks interleaved by the
// low two bits of the point index, so the four consecutive points of a segment are read
// together, one from each bank. Each stage has its own valid bit and moves whenever the
// stage after it is empty or moving, so bubbles close up and a stalled output register
// does not stop the input until every stage holds an item. A point write takes effect on
// the cycle it is accepted, so an evaluation beat that follows it directly already sees
// the new point. The node count register is written through the cfg port, which is always
// ready; it should change only while no beat is in flight. Writes are rejected at or
// beyond the count, and segments whose last point is at or beyond the count are rejected;
// rejected beats and writes return zero position and slope fields.
`timescale 1ns / 1ps
`include "catmull_rom_segment_eval_top_assert.svh"

module catmull_rom_segment_eval_top #(
  parameter int MAX_NODES   = crse_pkg::MAX_NODES_DEF,
  parameter int T_FRAC_BITS = crse_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  crse_pkg::crse_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output crse_pkg::crse_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crse_pkg::NODE_COUNT_W-1:0]   cfg_data
);
  import crse_pkg::*;

  localparam int T_W        = T_FRAC_BITS + 1;
  localparam int BANK_DEPTH = (MAX_NODES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [31:0] T_ONE = 32'd1 << T_FRAC_BITS;

  logic [NODE_COUNT_W-1:0] node_count_r;
  logic [NODE_COUNT_W-1:0] count_eff;
  logic [NODE_COUNT_W-1:0] seg_end;
  logic                    idx_ok;
  crse_status_t            in_status;
  logic [T_W-1:0]          t_clamped;
  logic                    wr_en_any;
  logic [15:0]             wr_row_wide;
  crse_point_t             wr_point;
  crse_point_t             bank_rd [NUM_BANKS];

  logic [STG_OUT+1:1]      en;
  logic [STG_OUT:1]        v_r;
  crse_status_t            status_r [1:STG_OUT-1];
  logic [BANK_SEL_W-1:0]   s1_sel_r;
  logic [T_W-1:0]          s1_t_r;

  logic [NUM_BANKS-1:0][COORD_W-1:0] word_x, word_y, word_z;
  logic signed [COORD_W-1:0] pos_x, pos_y, pos_z, slope_x, slope_y, slope_z;
  crse_out_t               out_nxt, out_r;

  logic                    rejected_out;
  logic                    geom_zero;

  // Configuration: a single register, taken in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_data;
    end
  end

  // A count above the table size acts as the table size.
  assign count_eff = (32'(node_count_r) > 32'(MAX_NODES)) ? NODE_COUNT_W'(MAX_NODES)
                                                          : node_count_r;

  // Status is settled on entry. A segment needs its fourth point below the count, which
  // also rejects every segment when fewer than four points are in use.
  always_comb begin
    seg_end = NODE_COUNT_W'(in_data.segment_index) + NODE_COUNT_W'(3);
    idx_ok  = NODE_COUNT_W'(in_data.node_index) < count_eff;
    case (in_data.operation)
      OP_WRITE: in_status = idx_ok ? ST_WRITE_OK : ST_BAD_INDEX;
      OP_EVAL:  in_status = (seg_end < count_eff) ? ST_EVAL : ST_BAD_SEG;
      default:  in_status = ST_BAD_SEG;
    endcase
  end

  // Parameters above one clamp to one.
  assign t_clamped = (32'(in_data.t_param) > T_ONE) ? T_W'(T_ONE) : T_W'(in_data.t_param);

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[STG_OUT+1] = out_ready;
    for (int k = STG_OUT; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[1];

  // Point store: the bank is the low two index bits, the row the remaining bits.
  assign wr_en_any   = in_valid && in_ready && (in_data.operation == OP_WRITE) && idx_ok;
  assign wr_row_wide = 16'(in_data.node_index) >> BANK_SEL_W;
  assign wr_point    = '{x: in_data.coord_x, y: in_data.coord_y, z: in_data.coord_z};

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [15:0] rd_row_wide;
    logic        bank_wr_en;

    // Bank b holds the one point of the segment whose index is congruent to b; its row
    // is (segment_index + 3 - b) / 4.
    assign rd_row_wide = (16'(in_data.segment_index) + 16'(NUM_BANKS - 1 - b)) >> BANK_SEL_W;
    assign bank_wr_en  = wr_en_any && (in_data.node_index[BANK_SEL_W-1:0] == BANK_SEL_W'(b));

    crse_bank_ram #(
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (bank_wr_en),
      .wr_addr (wr_row_wide[ROW_W-1:0]),
      .wr_data (wr_point),
      .rd_en   (in_ready),
      .rd_addr (rd_row_wide[ROW_W-1:0]),
      .rd_data (bank_rd[b])
    );
  end

  // Control pipeline: valid bits reset, payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= STG_OUT; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      status_r[1] <= in_status;
      s1_sel_r    <= in_data.segment_index[BANK_SEL_W-1:0];
      s1_t_r      <= t_clamped;
    end
    for (int k = 2; k <= STG_OUT - 1; k++) begin
      if (en[k]) begin
        status_r[k] <= status_r[k-1];
      end
    end
  end

  // Split the bank words per axis.
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      word_x[b] = bank_rd[b].x;
      word_y[b] = bank_rd[b].y;
      word_z[b] = bank_rd[b].z;
    end
  end

  crse_axis_pipe #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_axis_x (
    .clk   (clk),
    .en    (en[STG_OUT-1:2]),
    .word  (word_x),
    .sel   (s1_sel_r),
    .t_in  (s1_t_r),
    .pos   (pos_x),
    .slope (slope_x)
  );

  crse_axis_pipe #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_axis_y (
    .clk   (clk),
    .en    (en[STG_OUT-1:2]),
    .word  (word_y),
    .sel   (s1_sel_r),
    .t_in  (s1_t_r),
    .pos   (pos_y),
    .slope (slope_y)
  );

  crse_axis_pipe #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_axis_z (
    .clk   (clk),
    .en    (en[STG_OUT-1:2]),
    .word  (word_z),
    .sel   (s1_sel_r),
    .t_in  (s1_t_r),
    .pos   (pos_z),
    .slope (slope_z)
  );

  // Output register: writes and rejected beats carry zero geometry.
  always_comb begin
    out_nxt        = '0;
    out_nxt.status = status_r[STG_OUT-1];
    if (status_r[STG_OUT-1] == ST_EVAL) begin
      out_nxt.pos_x   = pos_x;
      out_nxt.pos_y   = pos_y;
      out_nxt.pos_z   = pos_z;
      out_nxt.slope_x = slope_x;
      out_nxt.slope_y = slope_y;
      out_nxt.slope_z = slope_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[STG_OUT];
  assign out_data  = out_r;

  assign rejected_out = out_valid && (out_data.status != ST_EVAL);
  assign geom_zero    = (out_data.pos_x == '0) && (out_data.pos_y == '0) &&
                        (out_data.pos_z == '0) && (out_data.slope_x == '0) &&
                        (out_data.slope_y == '0) && (out_data.slope_z == '0);

  // Only an evaluated beat may carry nonzero geometry.
  `CRSE_ASSERT_IMP(a_zero_geometry, rejected_out, geom_zero, "non-evaluated beat has geometry")
  // Input back-pressure only when every stage holds an item.
  `CRSE_ASSERT_IMP(a_full_when_blocked, !in_ready, &v_r, "input blocked with a bubble")
  // A valid item leaving the last compute stage lands in the output register.
  `CRSE_ASSERT_NXT(a_last_stage_moves, v_r[STG_OUT-1] && en[STG_OUT], out_valid, "item lost")

endmodule
